>>> rtl/core/rbpm_pkg.sv
`timescale 1ns / 1ps

package rbpm_pkg;

  // Default parameter values
  localparam int RowWidthDefault     = 20;
  localparam int RowCountDefault     = 64;
  localparam int ScreenWidthDefault  = 128;
  localparam int ScreenHeightDefault = 64;

  // Field widths of the request and result channels
  localparam int RowIdxW  = 6;
  localparam int RowBitsW = 20;
  localparam int AngleW   = 9;
  localparam int CxW      = 7;
  localparam int CyW      = 6;
  localparam int SxW      = 7;
  localparam int SyW      = 6;

  // Configuration register widths and reset values
  localparam int PivotXW   = 13;
  localparam int PivotYW   = 15;
  localparam int ZoomW     = 9;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 15;
  localparam logic [PivotXW-1:0] PivotXReset = PivotXW'(4378);
  localparam logic [PivotYW-1:0] PivotYReset = PivotYW'(161);
  localparam logic [ZoomW-1:0]   ZoomReset   = ZoomW'(205);

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegPivotX = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPivotY = 2'd1;
  localparam logic [CfgIdxW-1:0] RegZoom   = 2'd2;

  // Datapath widths
  localparam int TrigW = 16;              // Q1.15, -32767..32767
  localparam int DxW   = 16;              // x*256 - pivot_x
  localparam int DyW   = 17;              // y*256 - pivot_y
  localparam int ZmW   = ZoomW + 1;       // zoom as a signed operand
  localparam int PxW   = DxW + ZmW;       // Q.16 source offset, x
  localparam int PyW   = DyW + ZmW;       // Q.16 source offset, y
  localparam int PxProdW = PxW + TrigW;
  localparam int PyProdW = PyW + TrigW;
  localparam int SumW    = PyProdW + 1;   // Q.31 rotated coordinate
  localparam int FracSh  = 31;
  localparam int PosW    = 13;            // signed screen position after rounding

  // Bits of the column index into a row (covers any row width up to 64)
  localparam int ColIdxW = 6;

  // Row queue depth, a power of two
  localparam int QueueDepth = 2;

  // One queued row: everything the back end needs for its columns
  typedef struct packed {
    logic [RowBitsW-1:0]    row_bits;
    logic                   row_ok;
    logic signed [TrigW-1:0] sin_v;
    logic signed [TrigW-1:0] cos_v;
    logic signed [PyW-1:0]  py;
    logic [CxW-1:0]         cx;
    logic [CyW-1:0]         cy;
  } row_entry_t;

  // sin(d degrees) in Q1.15 for d = 0..90
  localparam logic [14:0] QuarterSine [91] = '{
    15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,  15'd2856,  15'd3425,
    15'd3993,  15'd4560,  15'd5126,  15'd5690,  15'd6252,  15'd6813,  15'd7371,
    15'd7927,  15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668, 15'd11207,
    15'd11743, 15'd12275, 15'd12803, 15'd13328, 15'd13848, 15'd14365, 15'd14876,
    15'd15384, 15'd15886, 15'd16384, 15'd16877, 15'd17364, 15'd17847, 15'd18324,
    15'd18795, 15'd19261, 15'd19720, 15'd20174, 15'd20622, 15'd21063, 15'd21498,
    15'd21926, 15'd22348, 15'd22763, 15'd23170, 15'd23571, 15'd23965, 15'd24351,
    15'd24730, 15'd25102, 15'd25466, 15'd25822, 15'd26170, 15'd26510, 15'd26842,
    15'd27166, 15'd27482, 15'd27789, 15'd28088, 15'd28378, 15'd28660, 15'd28932,
    15'd29197, 15'd29452, 15'd29698, 15'd29935, 15'd30163, 15'd30382, 15'd30592,
    15'd30792, 15'd30983, 15'd31164, 15'd31336, 15'd31499, 15'd31651, 15'd31795,
    15'd31928, 15'd32052, 15'd32166, 15'd32270, 15'd32365, 15'd32449, 15'd32524,
    15'd32588, 15'd32643, 15'd32688, 15'd32723, 15'd32748, 15'd32763, 15'd32767
  };

  // Sine of an angle already reduced to 0..359, by quadrant folding
  function automatic logic signed [TrigW-1:0] sine_deg(input logic [AngleW-1:0] a);
    logic [AngleW-1:0] idx;
    logic              neg;
    logic [TrigW-1:0]  mag;
    if (a <= AngleW'(90)) begin
      idx = a;
      neg = 1'b0;
    end else if (a <= AngleW'(180)) begin
      idx = AngleW'(180) - a;
      neg = 1'b0;
    end else if (a <= AngleW'(270)) begin
      idx = a - AngleW'(180);
      neg = 1'b1;
    end else begin
      idx = AngleW'(360) - a;
      neg = 1'b1;
    end
    mag = TrigW'(QuarterSine[idx[6:0]]);
    return neg ? $signed(-mag) : $signed(mag);
  endfunction

endpackage

>>> rtl/core/rbpm_front.sv
`timescale 1ns / 1ps

module rbpm_front import rbpm_pkg::*; #(
  parameter int ROW_COUNT = RowCountDefault
) (
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [RowIdxW-1:0]  row_index_i,
  input  logic [RowBitsW-1:0] row_bits_i,
  input  logic [AngleW-1:0]   angle_i,
  input  logic [CxW-1:0]      center_x_i,
  input  logic [CyW-1:0]      center_y_i,
  input  logic [PivotYW-1:0]  pivot_y_i,
  input  logic [ZoomW-1:0]    zoom_i,
  input  logic                full_i,
  output logic                push_o,
  output row_entry_t          entry_o
);

  logic [AngleW-1:0]     ang_s;
  logic [AngleW-1:0]     ang_c_raw;
  logic [AngleW-1:0]     ang_c;
  logic signed [DyW-1:0] dy;
  logic signed [ZmW-1:0] zm;
  logic signed [PyW-1:0] py;

  // Request handshake: take a row whenever the queue has room
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Angle modulo 360 for sine, plus 90 degrees for cosine
  assign ang_s     = (angle_i >= AngleW'(360)) ? angle_i - AngleW'(360) : angle_i;
  assign ang_c_raw = ang_s + AngleW'(90);
  assign ang_c     = (ang_c_raw >= AngleW'(360)) ? ang_c_raw - AngleW'(360) : ang_c_raw;

  // Row offset from the pivot, scaled by zoom (shared by all columns)
  assign dy = $signed(DyW'({row_index_i, 8'h00})) - $signed(DyW'(pivot_y_i));
  assign zm = $signed({1'b0, zoom_i});
  assign py = dy * zm;

  // Queue entry
  always_comb begin
    entry_o.row_bits = row_bits_i;
    entry_o.row_ok   = ({3'b000, row_index_i} < 9'(ROW_COUNT));
    entry_o.sin_v    = sine_deg(ang_s);
    entry_o.cos_v    = sine_deg(ang_c);
    entry_o.py       = py;
    entry_o.cx       = center_x_i;
    entry_o.cy       = center_y_i;
  end

endmodule

>>> rtl/core/rbpm_queue.sv
`timescale 1ns / 1ps

module rbpm_queue import rbpm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  row_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       head_valid_o,
  output row_entry_t head_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  row_entry_t        slot_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = slot_q[rd_ptr_q];

  // Pointer and fill count update (depth is a power of two, pointers wrap)
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/core/rbpm_back.sv
`timescale 1ns / 1ps

module rbpm_back import rbpm_pkg::*; #(
  parameter int ROW_WIDTH     = RowWidthDefault,
  parameter int SCREEN_WIDTH  = ScreenWidthDefault,
  parameter int SCREEN_HEIGHT = ScreenHeightDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [PivotXW-1:0] pivot_x_i,
  input  logic [ZoomW-1:0]   zoom_i,
  input  logic               head_valid_i,
  input  row_entry_t         head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SxW-1:0]     screen_x_o,
  output logic [SyW-1:0]     screen_y_o,
  output logic               draw_o,
  output logic               last_o
);

  localparam int XW = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
  localparam logic [XW-1:0] ColLast = XW'(ROW_WIDTH - 1);

  logic                    adv;
  logic                    issue;
  logic                    col_last;
  logic [XW-1:0]           col_q;
  logic [63:0]             bits_ext;
  logic                    pix_set;

  // Stage 1: issued column
  logic                    v1_q;
  logic [XW-1:0]           x1_q;
  logic                    set1_q, last1_q;
  logic signed [TrigW-1:0] s1_q, c1_q;
  logic signed [PyW-1:0]   py1_q;
  logic [CxW-1:0]          cx1_q;
  logic [CyW-1:0]          cy1_q;

  // Stage 2: scaled column offset
  logic                    v2_q;
  logic                    set2_q, last2_q;
  logic signed [TrigW-1:0] s2_q, c2_q;
  logic signed [PxW-1:0]   px2_q;
  logic signed [PyW-1:0]   py2_q;
  logic [CxW-1:0]          cx2_q;
  logic [CyW-1:0]          cy2_q;
  logic signed [DxW-1:0]   dx;
  logic signed [ZmW-1:0]   zm;
  logic signed [PxW-1:0]   px_d;

  // Stage 3: rotation products
  logic                      v3_q;
  logic                      set3_q, last3_q;
  logic signed [PxProdW-1:0] pxc_q, pxs_q;
  logic signed [PyProdW-1:0] pys_q, pyc_q;
  logic [CxW-1:0]            cx3_q;
  logic [CyW-1:0]            cy3_q;
  logic signed [PxProdW-1:0] pxc_d, pxs_d;
  logic signed [PyProdW-1:0] pys_d, pyc_d;

  // Stage 4: rotated coordinates, Q.31
  logic                   v4_q;
  logic                   set4_q, last4_q;
  logic signed [SumW-1:0] u4_q, w4_q;
  logic [CxW-1:0]         cx4_q;
  logic [CyW-1:0]         cy4_q;

  // Output stage
  logic signed [SumW-1:0] u_rnd, w_rnd;
  logic signed [SumW-1:0] u_q31, w_q31;
  logic signed [PosW-1:0] rx, ry;
  logic                   on_screen;
  logic                   draw_d;
  logic                   out_valid_q;
  logic [SxW-1:0]         sx_q;
  logic [SyW-1:0]         sy_q;
  logic                   draw_q, last_q;

  // Whole pipeline moves when the result register is free or being taken
  assign adv      = !out_valid_q || out_ready_i;
  assign issue    = adv && head_valid_i;
  assign col_last = (col_q == ColLast);
  assign pop_o    = issue && col_last;

  // Pixel bit of the issued column; columns past the row field read unset
  assign bits_ext = 64'(head_i.row_bits);
  assign pix_set  = head_i.row_ok && bits_ext[ColIdxW'(col_q)];

  // Column counter walks the head row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (issue) begin
      col_q <= col_last ? '0 : col_q + 1'b1;
    end
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= issue;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  // Column offset from the pivot, scaled by zoom
  assign dx   = $signed(DxW'({x1_q, 8'h00})) - $signed(DxW'(pivot_x_i));
  assign zm   = $signed({1'b0, zoom_i});
  assign px_d = dx * zm;

  // Rotation products
  assign pxc_d = px2_q * c2_q;
  assign pxs_d = px2_q * s2_q;
  assign pys_d = py2_q * s2_q;
  assign pyc_d = py2_q * c2_q;

  // Divide by 2^31 rounding half away from zero, then place on the screen
  assign u_rnd = u4_q + $signed(SumW'(64'd1 << 30)) - $signed(SumW'(u4_q < 0));
  assign w_rnd = w4_q + $signed(SumW'(64'd1 << 30)) - $signed(SumW'(w4_q < 0));
  assign u_q31 = u_rnd >>> FracSh;
  assign w_q31 = w_rnd >>> FracSh;
  assign rx    = $signed(PosW'(cx4_q)) + $signed(u_q31[PosW-1:0]);
  assign ry    = $signed(PosW'(cy4_q)) + $signed(w_q31[PosW-1:0]);
  assign on_screen = (rx >= 0) && (rx < $signed(PosW'(SCREEN_WIDTH))) &&
                     (ry >= 0) && (ry < $signed(PosW'(SCREEN_HEIGHT)));
  assign draw_d    = set4_q && on_screen;

  // Payload pipeline
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q    <= col_q;
      set1_q  <= pix_set;
      last1_q <= col_last;
      s1_q    <= head_i.sin_v;
      c1_q    <= head_i.cos_v;
      py1_q   <= head_i.py;
      cx1_q   <= head_i.cx;
      cy1_q   <= head_i.cy;

      set2_q  <= set1_q;
      last2_q <= last1_q;
      s2_q    <= s1_q;
      c2_q    <= c1_q;
      px2_q   <= px_d;
      py2_q   <= py1_q;
      cx2_q   <= cx1_q;
      cy2_q   <= cy1_q;

      set3_q  <= set2_q;
      last3_q <= last2_q;
      pxc_q   <= pxc_d;
      pxs_q   <= pxs_d;
      pys_q   <= pys_d;
      pyc_q   <= pyc_d;
      cx3_q   <= cx2_q;
      cy3_q   <= cy2_q;

      set4_q  <= set3_q;
      last4_q <= last3_q;
      u4_q    <= SumW'(pxc_q) - SumW'(pys_q);
      w4_q    <= SumW'(pxs_q) + SumW'(pyc_q);
      cx4_q   <= cx3_q;
      cy4_q   <= cy3_q;

      sx_q    <= draw_d ? rx[SxW-1:0] : '0;
      sy_q    <= draw_d ? ry[SyW-1:0] : '0;
      draw_q  <= draw_d;
      last_q  <= last4_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;
  assign draw_o      = draw_q;
  assign last_o      = last_q;

endmodule

>>> rtl/core/rotated_bitmap_pixel_mapper_top.sv
`timescale 1ns / 1ps

// Rotated bitmap pixel mapper. Each request carries one row of a one-bit
// sprite plus its row number, an angle in whole degrees and a screen center;
// the block returns ROW_WIDTH results in column order, one per column, with
// the rotated, zoomed screen coordinate and a draw flag (clear
// for unset or off-screen pixels), and last high on the final column. Pivot
// and zoom (Q.8) are to be written through the cfg port only while the block
// is idle; the block itself does not enforce this. The front end does the
// sine/cosine lookup and row-dependent math when a request is taken and parks
// the row in a two-entry queue; the back end walks the columns of the queued
// row and issues one column per cycle, unless the result channel stalls, into a
// five-stage multiply pipeline. The next row is taken while the current one is
// still being mapped.

module rotated_bitmap_pixel_mapper_top import rbpm_pkg::*; #(
  parameter int ROW_WIDTH     = RowWidthDefault,
  parameter int ROW_COUNT     = RowCountDefault,
  parameter int SCREEN_WIDTH  = ScreenWidthDefault,
  parameter int SCREEN_HEIGHT = ScreenHeightDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // Request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [RowIdxW-1:0]  row_index_i,
  input  logic [RowBitsW-1:0] row_bits_i,
  input  logic [AngleW-1:0]   angle_i,
  input  logic [CxW-1:0]      center_x_i,
  input  logic [CyW-1:0]      center_y_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SxW-1:0]      screen_x_o,
  output logic [SyW-1:0]      screen_y_o,
  output logic                draw_o,
  output logic                last_o
);

  logic [PivotXW-1:0] pivot_x_q;
  logic [PivotYW-1:0] pivot_y_q;
  logic [ZoomW-1:0]   zoom_q;

  logic       push;
  logic       full;
  logic       pop;
  logic       head_valid;
  row_entry_t entry;
  row_entry_t head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_x_q <= PivotXReset;
      pivot_y_q <= PivotYReset;
      zoom_q    <= ZoomReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPivotX: pivot_x_q <= cfg_wdata_i[PivotXW-1:0];
        RegPivotY: pivot_y_q <= cfg_wdata_i[PivotYW-1:0];
        RegZoom:   zoom_q    <= cfg_wdata_i[ZoomW-1:0];
        default: ;
      endcase
    end
  end

  rbpm_front #(
    .ROW_COUNT (ROW_COUNT)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .row_index_i (row_index_i),
    .row_bits_i  (row_bits_i),
    .angle_i     (angle_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .pivot_y_i   (pivot_y_q),
    .zoom_i      (zoom_q),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (entry)
  );

  rbpm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  rbpm_back #(
    .ROW_WIDTH     (ROW_WIDTH),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pivot_x_i    (pivot_x_q),
    .zoom_i       (zoom_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .screen_x_o   (screen_x_o),
    .screen_y_o   (screen_y_o),
    .draw_o       (draw_o),
    .last_o       (last_o)
  );

endmodule

>>> verif/rbpm_pixel_checker.sv
`timescale 1ns / 1ps

module rbpm_pixel_checker import rbpm_pkg::*; #(
  parameter int ROW_WIDTH     = RowWidthDefault,
  parameter int ROW_COUNT     = RowCountDefault,
  parameter int SCREEN_WIDTH  = ScreenWidthDefault,
  parameter int SCREEN_HEIGHT = ScreenHeightDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_o,
  input  logic [RowIdxW-1:0]  row_index_i,
  input  logic [RowBitsW-1:0] row_bits_i,
  input  logic [AngleW-1:0]   angle_i,
  input  logic [CxW-1:0]      center_x_i,
  input  logic [CyW-1:0]      center_y_i,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic [SxW-1:0]      screen_x_o,
  input  logic [SyW-1:0]      screen_y_o,
  input  logic                draw_o,
  input  logic                last_o,
  output int                  mismatch_count_o,
  output int                  pixels_pending_o
);

  // sin(d) in Q1.15 for d = 0..90
  localparam int SinQuarter [91] = '{
    0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
    5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32767
  };

  typedef struct packed {
    logic [SxW-1:0] sx;
    logic [SyW-1:0] sy;
    logic           draw;
    logic           last;
  } pixel_t;

  logic [PivotXW-1:0] pivot_x_q;
  logic [PivotYW-1:0] pivot_y_q;
  logic [ZoomW-1:0]   zoom_q;
  pixel_t             expected_pixels [$];
  pixel_t             got, want;
  int                 fails;

  // Whole-degree sine, any angle folded into one quadrant
  function automatic longint sine_q15(input int unsigned deg);
    int unsigned a;
    a = deg % 360;
    if (a <= 90) return SinQuarter[a];
    else if (a <= 180) return SinQuarter[180 - a];
    else if (a <= 270) return -SinQuarter[a - 180];
    else return -SinQuarter[360 - a];
  endfunction

  // Q.31 to integer, half away from zero
  function automatic longint round_q31(input longint v);
    longint mag, q;
    mag = (v < 0) ? -v : v;
    q = (mag + (64'sd1 <<< 30)) >>> 31;
    return (v < 0) ? -q : q;
  endfunction

  // Map every column of one row to its screen position
  task automatic map_row(input logic [RowIdxW-1:0] row, input logic [RowBitsW-1:0] bits,
                         input logic [AngleW-1:0] ang, input logic [CxW-1:0] cx,
                         input logic [CyW-1:0] cy);
    longint s, c, r, py, px, rx, ry;
    pixel_t pix;
    s = sine_q15(int'(ang));
    c = sine_q15(int'(ang) + 90);
    r = row;
    py = (r * 256 - longint'(pivot_y_q)) * longint'(zoom_q);
    for (int x = 0; x < ROW_WIDTH; x++) begin
      pix = '0;
      pix.last = (x == ROW_WIDTH - 1);
      if (x < RowBitsW && row < ROW_COUNT && bits[x]) begin
        px = (longint'(x) * 256 - longint'(pivot_x_q)) * longint'(zoom_q);
        rx = longint'(cx) + round_q31(px * c - py * s);
        ry = longint'(cy) + round_q31(px * s + py * c);
        if (rx >= 0 && rx < SCREEN_WIDTH && ry >= 0 && ry < SCREEN_HEIGHT) begin
          pix.sx   = SxW'(rx);
          pix.sy   = SyW'(ry);
          pix.draw = 1'b1;
        end
      end
      expected_pixels.push_back(pix);
    end
  endtask

  // Track registers, predict on each request, compare each result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_x_q <= PivotXReset;
      pivot_y_q <= PivotYReset;
      zoom_q    <= ZoomReset;
      expected_pixels.delete();
      fails = 0;
      mismatch_count_o <= 0;
      pixels_pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPivotX: pivot_x_q <= cfg_wdata_i[PivotXW-1:0];
          RegPivotY: pivot_y_q <= cfg_wdata_i[PivotYW-1:0];
          RegZoom:   zoom_q    <= cfg_wdata_i[ZoomW-1:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        got = '{screen_x_o, screen_y_o, draw_o, last_o};
        if (expected_pixels.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, got x=%0d y=%0d draw=%0b last=%0b",
                   $time, got.sx, got.sy, got.draw, got.last);
        end else begin
          want = expected_pixels.pop_front();
          if (got.sx !== want.sx || got.sy !== want.sy || got.draw !== want.draw ||
              got.last !== want.last) begin
            fails++;
            $display("%0t: pixel mismatch, expected x=%0d y=%0d draw=%0b last=%0b, %s%0d %0d %0b %0b",
                     $time, want.sx, want.sy, want.draw, want.last, "got x/y/draw/last=",
                     got.sx, got.sy, got.draw, got.last);
          end
        end
      end
      if (in_valid_i && in_ready_o)
        map_row(row_index_i, row_bits_i, angle_i, center_x_i, center_y_i);
      mismatch_count_o <= fails;
      pixels_pending_o <= expected_pixels.size();
    end
  end

endmodule

>>> verif/rotated_bitmap_pixel_mapper_top_test.sv
`timescale 1ns / 1ps

module rotated_bitmap_pixel_mapper_top_test;
  import rbpm_pkg::*;

  localparam int RowsPerPhase = 56;
  localparam int PhaseCount   = 8;
  localparam int StallLimit   = 5000;
  localparam int DrainCycles  = 16;
  // index with no register behind it
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  typedef enum logic [1:0] {SinkOpen, SinkRandom, SinkPeriodic, SinkThrottle} sink_mode_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [RowIdxW-1:0]  row_index_i = '0;
  logic [RowBitsW-1:0] row_bits_i  = '0;
  logic [AngleW-1:0]   angle_i     = '0;
  logic [CxW-1:0]      center_x_i  = '0;
  logic [CyW-1:0]      center_y_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [SxW-1:0]      screen_x_o;
  logic [SyW-1:0]      screen_y_o;
  logic                draw_o;
  logic                last_o;

  int          mismatch_count;
  int          pixels_pending;
  int          idle_cycles = 0;
  int unsigned sink_cycle  = 0;

  rotated_bitmap_pixel_mapper_top DUT (.*);

  rbpm_pixel_checker pixel_checker (
    .*,
    .mismatch_count_o(mismatch_count),
    .pixels_pending_o(pixels_pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Result sink: rotates through open, random, periodic and throttled stalls
  always @(posedge clk_i) begin
    sink_cycle <= sink_cycle + 1;
    case (sink_mode_e'((sink_cycle / 97) % 4))
      SinkOpen:     out_ready_i <= 1'b1;
      SinkRandom:   out_ready_i <= 1'($urandom_range(0, 1));
      SinkPeriodic: out_ready_i <= (sink_cycle % 8) < 5;
      default:      out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("rotated_bitmap_pixel_mapper_top_test failed");
      $finish;
    end
  end

  // Present one request and hold it until taken
  task automatic send_row(input logic [RowIdxW-1:0] row, input logic [RowBitsW-1:0] bits,
                          input logic [AngleW-1:0] ang, input logic [CxW-1:0] cx,
                          input logic [CyW-1:0] cy);
    in_valid_i  <= 1'b1;
    row_index_i <= row;
    row_bits_i  <= bits;
    angle_i     <= ang;
    center_x_i  <= cx;
    center_y_i  <= cy;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random_row();
    logic [RowBitsW-1:0] bits;
    logic [AngleW-1:0]   ang;
    case ($urandom_range(0, 9))
      0:       bits = '1;
      1:       bits = RowBitsW'(1) << $urandom_range(0, RowBitsW - 1);
      2:       bits = '0;
      default: bits = RowBitsW'($urandom);
    endcase
    // right angles and their wrapped forms get extra weight
    if ($urandom_range(0, 4) == 0) ang = AngleW'(90 * $urandom_range(0, 5));
    else ang = AngleW'($urandom_range(0, (1 << AngleW) - 1));
    send_row(RowIdxW'($urandom), bits, ang, CxW'($urandom), CyW'($urandom));
  endtask

  // Drop valid, then wait until every pixel of the queued rows is out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pixels_pending != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Pivot and zoom per phase: extremes and a fixed setting first, then random settings
  task automatic load_config(input int phase);
    logic [CfgDataW-1:0] px, py, zm;
    case (phase)
      0: begin
        px = '0; py = '0; zm = '0;
      end
      1: begin
        px = CfgDataW'(5120); py = CfgDataW'(16384); zm = CfgDataW'(511);
      end
      2: begin
        // all ones, wider than pivot_x and zoom
        px = '1; py = '1; zm = '1;
      end
      3: begin
        px = CfgDataW'(2432); py = CfgDataW'(4032); zm = CfgDataW'(256);
      end
      7: begin
        px = CfgDataW'($urandom); py = CfgDataW'($urandom); zm = CfgDataW'($urandom);
      end
      default: begin
        px = CfgDataW'($urandom_range(0, 5120));
        py = CfgDataW'($urandom_range(0, 16384));
        zm = CfgDataW'($urandom_range(64, 511));
      end
    endcase
    write_reg(RegZoom, zm);
    write_reg(RegPivotX, px);
    write_reg(RegPivotY, py);
    if (phase == 3) write_reg(RegSpare, CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int burst_left;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at the reset settings, back to back
    send_row(6'd0,  20'hFFFFF, 9'd0,   7'd64,  6'd32);
    send_row(6'd63, 20'hFFFFF, 9'd90,  7'd64,  6'd32);
    send_row(6'd17, 20'h55555, 9'd180, 7'd0,   6'd0);
    send_row(6'd1,  20'hAAAAA, 9'd270, 7'd127, 6'd63);
    send_row(6'd32, 20'hFFFFF, 9'd359, 7'd64,  6'd32);
    send_row(6'd32, 20'hFFFFF, 9'd360, 7'd64,  6'd32);
    send_row(6'd10, 20'hFFFFF, 9'd450, 7'd64,  6'd32);
    send_row(6'd5,  20'hFFFFF, 9'd511, 7'd64,  6'd32);
    send_row(6'd0,  20'h00000, 9'd45,  7'd127, 6'd63);
    send_row(6'd63, 20'h80001, 9'd135, 7'd0,   6'd63);
    send_row(6'd20, 20'hFFFFF, 9'd225, 7'd127, 6'd0);
    send_row(6'd30, 20'h0F0F0, 9'd315, 7'd70,  6'd40);
    send_row(6'd8,  20'h80000, 9'd1,   7'd64,  6'd32);
    send_row(6'd40, 20'hFFFFF, 9'd89,  7'd20,  6'd10);
    send_row(6'd63, 20'hFFFFF, 9'd181, 7'd0,   6'd0);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain_results();
      load_config(phase);
      burst_left = 0;
      for (int n = 0; n < RowsPerPhase; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          // phases 1 and 5 run without sender gaps
          if (phase % 4 != 1 && $urandom_range(0, 3) != 0) begin
            in_valid_i <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk_i);
          end
        end
        send_random_row();
        burst_left--;
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("rotated_bitmap_pixel_mapper_top_test passed");
    end else begin
      $display("rotated_bitmap_pixel_mapper_top_test failed");
    end
    $finish;
  end

endmodule
